FILE: rtl/core/fasta_motif_site_counter_top_macros.svh
// ----------------------------------------------------------------------------
// FASTA motif site counter assertion macros
// Shared property forms for the checkers of the motif site counter.
// ----------------------------------------------------------------------------
`ifndef FASTA_MOTIF_SITE_COUNTER_TOP_MACROS_SVH
`define FASTA_MOTIF_SITE_COUNTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fms check failed");

// The consequent must hold in the cycle after the antecedent.
`define FMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fms check failed");

`endif

FILE: rtl/core/fms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter package
// Types, constants and helper functions shared by the counter modules.
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 64;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_PATTERN_CHARS  = 1'b1;

    localparam logic [3:0]  PATTERN_LENGTH_RESET = 4'd2;
    localparam logic [63:0] PATTERN_CHARS_RESET  = 64'h0000_0000_0000_4743;

    localparam logic [7:0] CHAR_HEADER  = 8'h3e;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_MASK    = 8'hdf;
    localparam logic [7:0] BASE_A       = 8'h41;
    localparam logic [7:0] BASE_C       = 8'h43;
    localparam logic [7:0] BASE_G       = 8'h47;
    localparam logic [7:0] BASE_T       = 8'h54;

    localparam logic [1:0] OP_SEQ    = 2'd0;
    localparam logic [1:0] OP_HEADER = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] record_sites;
        logic [31:0] total_sites;
        logic        is_final;
    } result_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] base;
    } op_t;

    typedef struct packed {
        logic [3:0]  pattern_length;
        logic [63:0] pattern_chars;
    } cfg_t;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        upcase = (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ? (b & CASE_MASK) : b;
    endfunction

    function automatic logic [7:0] complement_base(input logic [7:0] c);
        case (c)
            BASE_A:  complement_base = BASE_T;
            BASE_T:  complement_base = BASE_A;
            BASE_C:  complement_base = BASE_G;
            BASE_G:  complement_base = BASE_C;
            default: complement_base = c;
        endcase
    endfunction

endpackage

FILE: rtl/core/fms_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter queue
// Small synchronous first-in first-out queue; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module fms_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ((wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1)
                            : wr_ptr_reg;
        rd_ptr_next = do_rd ? ((rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                            : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/fms_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter registers
// APB-style register file holding the pattern length and pattern bytes.
// ----------------------------------------------------------------------------
module fms_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fms_pkg::ADDR_W-1:0]   paddr,
    input  logic [fms_pkg::DATA_W-1:0]   pwdata,
    output logic [fms_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output fms_pkg::cfg_t                cfg
);

    import fms_pkg::*;

    logic [3:0]  pattern_length_reg;
    logic [3:0]  pattern_length_next;
    logic [63:0] pattern_chars_reg;
    logic [63:0] pattern_chars_next;
    logic        wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;

    always_comb
    begin
        pattern_length_next = pattern_length_reg;
        pattern_chars_next  = pattern_chars_reg;
        if (wr_fire)
        begin
            unique case (paddr[3])
                REG_PATTERN_LENGTH: pattern_length_next = pwdata[3:0];
                REG_PATTERN_CHARS:  pattern_chars_next  = pwdata;
                default:            pattern_chars_next  = pattern_chars_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_PATTERN_LENGTH: prdata = {60'd0, pattern_length_reg};
            REG_PATTERN_CHARS:  prdata = pattern_chars_reg;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            pattern_chars_reg  <= PATTERN_CHARS_RESET;
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
            pattern_chars_reg  <= pattern_chars_next;
        end
    end

    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.pattern_chars  = pattern_chars_reg;

endmodule

FILE: rtl/core/fms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter front end
// Tracks line and header state and turns file bytes into window operations.
// ----------------------------------------------------------------------------
module fms_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fms_pkg::item_t item,
    input  logic           q_full,
    output logic           q_push,
    output fms_pkg::op_t   q_op
);

    import fms_pkg::*;

    logic in_header_reg;
    logic in_header_next;
    logic at_line_start_reg;
    logic at_line_start_next;
    logic accept;
    logic op_valid;

    assign accept = push && !q_full;

    always_comb
    begin
        in_header_next     = in_header_reg;
        at_line_start_next = at_line_start_reg;
        op_valid           = 1'b0;
        q_op.op            = OP_SEQ;
        q_op.base          = upcase(item.data_byte);
        if (item.mode)
        begin
            in_header_next     = 1'b0;
            at_line_start_next = 1'b1;
            op_valid           = 1'b1;
            q_op.op            = OP_END;
        end
        else if (item.data_byte == CHAR_NEWLINE)
        begin
            in_header_next     = 1'b0;
            at_line_start_next = 1'b1;
        end
        else if (at_line_start_reg && item.data_byte == CHAR_HEADER)
        begin
            in_header_next     = 1'b1;
            at_line_start_next = 1'b0;
            op_valid           = 1'b1;
            q_op.op            = OP_HEADER;
        end
        else
        begin
            at_line_start_next = 1'b0;
            op_valid           = !in_header_reg;
        end
    end

    assign q_push = accept && op_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg     <= 1'b0;
            at_line_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            in_header_reg     <= in_header_next;
            at_line_start_reg <= at_line_start_next;
        end
    end

endmodule

FILE: rtl/core/fms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter back end
// Shifts sequence bytes into the window, matches the pattern and its
// complement, and keeps the record and running totals.
// ----------------------------------------------------------------------------
module fms_back #(
    parameter int unsigned MAX_PATTERN = fms_pkg::MAX_PATTERN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fms_pkg::cfg_t    cfg,
    input  logic             q_empty,
    input  fms_pkg::op_t     q_op,
    output logic             q_pop,
    input  logic             res_full,
    output logic             res_push,
    output fms_pkg::result_t res
);

    import fms_pkg::*;

    localparam int unsigned FW = $clog2(MAX_PATTERN + 1);
    localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]    window_reg [MAX_PATTERN];
    logic [7:0]    window_new [MAX_PATTERN];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] fill_new;
    logic          has_seq_reg;
    logic          has_seq_next;
    logic [31:0]   count_reg;
    logic [31:0]   count_next;
    logic [31:0]   total_reg;
    logic [31:0]   total_next;
    logic [31:0]   total_sum;
    logic [3:0]    len_eff;
    logic          fwd_hit;
    logic          cmp_hit;
    logic          span_ok;
    logic [1:0]    hit_count;
    logic          take;
    logic          shift_en;

    assign take    = !q_empty && !res_full;
    assign q_pop   = take;
    assign len_eff = (cfg.pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                            : cfg.pattern_length;
    assign fill_new = (fill_reg == FW'(MAX_PATTERN)) ? fill_reg : fill_reg + 1'b1;

    always_comb
    begin
        window_new[0] = q_op.base;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_new[i] = window_reg[i-1];
        end
    end

    always_comb
    begin : match_blk
        logic [3:0] idx;
        logic [7:0] w;
        logic [7:0] p;
        fwd_hit = 1'b1;
        cmp_hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx = len_eff - 4'd1 - 4'(k);
            w   = window_new[idx[IW-1:0]];
            p   = cfg.pattern_chars[8*k +: 8];
            if (4'(k) < len_eff)
            begin
                if (w != p)
                begin
                    fwd_hit = 1'b0;
                end
                if (w != complement_base(p))
                begin
                    cmp_hit = 1'b0;
                end
            end
        end
    end

    assign span_ok = (len_eff != 4'd0) && (4'(fill_new) >= len_eff);
    assign hit_count = {1'b0, fwd_hit && span_ok} + {1'b0, cmp_hit && span_ok};
    assign total_sum = total_reg + count_reg;

    always_comb
    begin
        fill_next    = fill_reg;
        has_seq_next = has_seq_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        res_push     = 1'b0;
        shift_en     = 1'b0;
        res.record_sites = count_reg;
        res.total_sites  = total_sum;
        res.is_final     = (q_op.op == OP_END);
        if (take)
        begin
            unique case (q_op.op)
                OP_SEQ:
                begin
                    shift_en     = 1'b1;
                    fill_next    = fill_new;
                    has_seq_next = 1'b1;
                    count_next   = count_reg + 32'(hit_count);
                end
                OP_HEADER:
                begin
                    res_push     = has_seq_reg;
                    total_next   = has_seq_reg ? total_sum : total_reg;
                    fill_next    = '0;
                    has_seq_next = 1'b0;
                    count_next   = '0;
                end
                OP_END:
                begin
                    res_push     = 1'b1;
                    total_next   = total_sum;
                    fill_next    = '0;
                    has_seq_next = 1'b0;
                    count_next   = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            has_seq_reg <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            has_seq_reg <= has_seq_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= window_new[i];
            end
        end
    end

endmodule

FILE: rtl/core/fasta_motif_site_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter
// Counts pattern and complement sites per record of a FASTA byte stream.
// ----------------------------------------------------------------------------
// Input channel: push with item (mode, data_byte); a transaction completes when
// push is high and full is low. One item is taken every cycle while full is low.
// Result channel: the oldest result (record_sites, total_sites, is_final) is
// shown while empty is low; a transaction completes when pop is high and empty
// is low. An item is registered in the operation queue, and its result in the
// result queue after the back end's window compare and count update. Throughput
// is one item per cycle while full is low. When pop stays low the result queue
// fills, the back end stops draining the operation queue, and full rises once
// that queue is full as well. The pattern registers sit on an APB-style port
// and must be written only while the block is idle; the block does not enforce
// this. Reset empties both queues, clears all counts and the line state, and
// loads a pattern length of two with the pattern CG.
// ----------------------------------------------------------------------------
module fasta_motif_site_counter_top #(
    parameter int unsigned MAX_PATTERN = fms_pkg::MAX_PATTERN_DEF,
    parameter int unsigned QUEUE_DEPTH = fms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  fms_pkg::item_t             item,
    output logic                       empty,
    input  logic                       pop,
    output fms_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fms_pkg::ADDR_W-1:0] paddr,
    input  logic [fms_pkg::DATA_W-1:0] pwdata,
    output logic [fms_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    import fms_pkg::*;

    cfg_t    cfg;
    logic    op_push;
    op_t     op_in;
    logic    op_pop;
    logic    op_empty;
    logic [$bits(op_t)-1:0]     op_out_bits;
    logic    res_push;
    logic    res_full;
    result_t res_in;
    logic [$bits(result_t)-1:0] res_out_bits;

    fms_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fms_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (full),
        .q_push (op_push),
        .q_op   (op_in)
    );

    fms_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (op_in),
        .rd_en   (op_pop),
        .rd_data (op_out_bits),
        .full    (full),
        .empty   (op_empty)
    );

    fms_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (op_empty),
        .q_op     (op_t'(op_out_bits)),
        .q_pop    (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    fms_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out_bits),
        .full    (res_full),
        .empty   (empty)
    );

    assign result = result_t'(res_out_bits);

endmodule

FILE: rtl/core/fms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FASTA motif site counter checker
// Port-level checks on result ordering, totals and queue backpressure.
// ----------------------------------------------------------------------------
`include "fasta_motif_site_counter_top_macros.svh"

module fms_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input fms_pkg::item_t   item,
    input logic             empty,
    input logic             pop,
    input fms_pkg::result_t result
);

    import fms_pkg::*;

    logic [31:0] last_total_reg;
    logic [31:0] last_total_next;
    logic [31:0] expect_total;
    logic        in_seen;

    assign in_seen         = push && !full && (item.mode || !item.mode);
    assign expect_total    = last_total_reg + result.record_sites;
    assign last_total_next = (pop && !empty) ? result.total_sites : last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else
        begin
            last_total_reg <= last_total_next;
        end
    end

    // A waiting result keeps its place and its value until it is taken.
    `FMS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

    // Each taken result adds its record count to the previous running total.
    `FMS_ASSERT_SAME(a_total_sums, !empty && pop, result.total_sites == expect_total)

    // Input backpressure only arises when results are backed up.
    `FMS_ASSERT_SAME(a_full_needs_backlog, full, !empty)

    // No transaction is taken on the input side while it reports full.
    `FMS_ASSERT_SAME(a_no_accept_when_full, full, !in_seen)

endmodule

bind fasta_motif_site_counter_top fms_checker u_checker (.*);
